@@ rtl/core/p2f_pkg.sv @@
// Shared types and codes for the page to frame map.
package p2f_pkg;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_LOOKUP = 2'd1,
		OP_DELETE = 2'd2,
		OP_NONE   = 2'd3
	} req_op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		SLOT_EMPTY   = 2'd0,
		SLOT_USED    = 2'd1,
		SLOT_DELETED = 2'd2
	} slot_state_t;

	typedef struct packed {
		req_op_t     op;
		logic [31:0] key;
		logic [15:0] frame;
	} item_t;

	typedef struct packed {
		slot_state_t st;
		logic [31:0] key;
		logic [15:0] frame;
	} slot_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_flags_t;

endpackage

@@ rtl/core/page_to_frame_map_top.sv @@
// Top level of the page to frame map: front end, request queue and probe engine.
//
//   Channel   Handshake                  Fields
//   request   start / busy               req_type, page_number, frame_number
//   result    done (one-cycle strobe)    status, frame_out, entry_count
//
// A request beat is taken on a clock edge where start is high and busy is low.
// Each request yields exactly one result beat, shown for one cycle while done is high.
// After reset the engine sweeps the slot memory to mark every slot empty, and busy
// stays high throughout.
// A request is registered in the front end, waits in the queue, is issued by the
// engine and then probes one slot at a time. With a well spread key set a request
// probes one to a few slots; the worst case is ENTRIES probes, set by the single
// read port of the slot memory. The result side cannot stall. The front end raises
// busy only during the memory sweep or while the queue is full and its own stage is
// occupied, so it keeps taking beats while the engine probes.
module page_to_frame_map_top import p2f_pkg::*; #(
	parameter int ENTRIES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [31:0] page_number,
	input  logic [15:0] frame_number,
	output logic        done,
	output logic [1:0]  status,
	output logic [15:0] frame_out,
	output logic [6:0]  entry_count
);

	// Slot index width and the width of the pair counter, which must hold ENTRIES.
	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CW    = $clog2(ENTRIES + 1);
	localparam int QW    = $bits(item_t) + IDX_W;

	logic             clearing;
	fifo_flags_t      q_flags;
	logic             push;
	item_t            push_item;
	logic [IDX_W-1:0] push_idx;
	logic             pop;
	logic [QW-1:0]    pop_data;
	item_t            q_item;
	logic [IDX_W-1:0] q_idx;

	p2f_front #(
		.ENTRIES (ENTRIES),
		.IDX_W   (IDX_W)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.req_type     (req_type),
		.page_number  (page_number),
		.frame_number (frame_number),
		.clearing     (clearing),
		.q_flags      (q_flags),
		.busy         (busy),
		.push         (push),
		.push_item    (push_item),
		.push_idx     (push_idx)
	);

	// Each queue entry carries the request and its home slot.
	p2f_queue #(
		.DW (QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_item, push_idx}),
		.pop       (pop),
		.pop_data  (pop_data),
		.flags     (q_flags)
	);

	assign {q_item, q_idx} = pop_data;

	p2f_back #(
		.ENTRIES (ENTRIES),
		.IDX_W   (IDX_W),
		.CW      (CW)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_flags     (q_flags),
		.q_item      (q_item),
		.q_idx       (q_idx),
		.pop         (pop),
		.clearing    (clearing),
		.done        (done),
		.status      (status),
		.frame_out   (frame_out),
		.entry_count (entry_count)
	);

endmodule

@@ rtl/core/p2f_front.sv @@
// Front end: accepts requests, classifies the code and hashes the page to a home slot.
module p2f_front import p2f_pkg::*; #(
	parameter int ENTRIES = 64,
	parameter int IDX_W   = 6
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [1:0]         req_type,
	input  logic [31:0]        page_number,
	input  logic [15:0]        frame_number,
	input  logic               clearing,
	input  fifo_flags_t        q_flags,
	output logic               busy,
	output logic               push,
	output item_t              push_item,
	output logic [IDX_W-1:0]   push_idx
);

	logic             valid_s1;
	item_t            item_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             accept;
	req_op_t          op_c;
	logic [IDX_W-1:0] fold_c;
	logic [IDX_W-1:0] home_c;

	// Codes outside the three requests become a no-operation.
	always_comb begin
		case (req_type)
			OP_INSERT: op_c = OP_INSERT;
			OP_LOOKUP: op_c = OP_LOOKUP;
			OP_DELETE: op_c = OP_DELETE;
			default:   op_c = OP_NONE;
		endcase
	end

	// XOR fold of the key, then one conditional subtract into the slot range.
	always_comb begin
		fold_c = '0;
		for (int i = 0; i < 32; i++) begin
			fold_c[i % IDX_W] = fold_c[i % IDX_W] ^ page_number[i];
		end
		if ({1'b0, fold_c} >= (IDX_W + 1)'(ENTRIES)) begin
			home_c = IDX_W'({1'b0, fold_c} - (IDX_W + 1)'(ENTRIES));
		end else begin
			home_c = fold_c;
		end
	end

	assign busy   = clearing || (valid_s1 && q_flags.full);
	assign accept = start && !busy;
	assign push   = valid_s1 && !q_flags.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= '{op: op_c, key: page_number, frame: frame_number};
			idx_s1  <= home_c;
		end
	end

	assign push_item = item_s1;
	assign push_idx  = idx_s1;

endmodule

@@ rtl/core/p2f_queue.sv @@
// Two-deep request queue between the front end and the probe engine.
module p2f_queue import p2f_pkg::*; #(
	parameter int DW = 56
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [DW-1:0] push_data,
	input  logic          pop,
	output logic [DW-1:0] pop_data,
	output fifo_flags_t   flags
);

	logic [DW-1:0] buf_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= push_data;
		end
	end

	assign pop_data    = buf_q[rd_ptr_q];
	assign flags.full  = (fill_q == 2'd2);
	assign flags.empty = (fill_q == 2'd0);

endmodule

@@ rtl/core/p2f_back.sv @@
// Probe engine: linear probing over the slot memory, with a clearing pass after reset.
module p2f_back import p2f_pkg::*; #(
	parameter int ENTRIES = 64,
	parameter int IDX_W   = 6,
	parameter int CW      = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  fifo_flags_t      q_flags,
	input  item_t            q_item,
	input  logic [IDX_W-1:0] q_idx,
	output logic             pop,
	output logic             clearing,
	output logic             done,
	output logic [1:0]       status,
	output logic [15:0]      frame_out,
	output logic [6:0]       entry_count
);

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_PROBE
	} state_t;

	state_t           state_q;
	slot_t            mem [ENTRIES];
	slot_t            rd_data_q;
	logic [IDX_W-1:0] rd_addr;
	logic             we;
	logic [IDX_W-1:0] waddr;
	slot_t            wdata;

	logic [IDX_W-1:0] clr_q;
	req_op_t          op_q;
	logic [31:0]      key_q;
	logic [15:0]      frame_q;
	logic [IDX_W-1:0] cur_q;
	logic [IDX_W-1:0] probes_q;
	logic             free_have_q;
	logic [IDX_W-1:0] free_idx_q;
	logic [CW-1:0]    count_q;
	logic             done_q;
	status_t          status_q;
	logic [15:0]      frame_out_q;

	logic             hit;
	logic             slot_free;
	logic             last;
	logic             finish;
	logic             ins_ok;
	logic [IDX_W-1:0] ins_idx;
	logic [IDX_W-1:0] next_idx;
	status_t          res_status;
	logic [15:0]      res_frame;
	logic [CW-1:0]    count_next;

	assign next_idx  = (cur_q == IDX_W'(ENTRIES - 1)) ? '0 : cur_q + IDX_W'(1);
	assign hit       = (rd_data_q.st == SLOT_USED) && (rd_data_q.key == key_q);
	assign slot_free = (rd_data_q.st != SLOT_USED);
	assign last      = (rd_data_q.st == SLOT_EMPTY) || (probes_q == IDX_W'(ENTRIES - 1));
	assign finish    = (state_q == S_PROBE) && (hit || last);
	assign ins_idx   = free_have_q ? free_idx_q : cur_q;
	assign ins_ok    = (free_have_q || slot_free) && (count_q < CW'(ENTRIES));

	assign pop      = (state_q == S_IDLE) && !q_flags.empty;
	assign clearing = (state_q == S_CLEAR);

	always_comb begin
		case (state_q)
			S_IDLE:  rd_addr = q_idx;
			S_PROBE: rd_addr = next_idx;
			default: rd_addr = '0;
		endcase
	end

	// Memory write and result of the probe that ends this cycle.
	always_comb begin
		we         = 1'b0;
		waddr      = cur_q;
		wdata      = '{st: SLOT_USED, key: key_q, frame: frame_q};
		res_status = ST_NOT_FOUND;
		res_frame  = '0;
		count_next = count_q;
		if (state_q == S_CLEAR) begin
			we    = 1'b1;
			waddr = clr_q;
			wdata = '{st: SLOT_EMPTY, key: '0, frame: '0};
		end else if (finish) begin
			if (hit) begin
				res_status = ST_OK;
				case (op_q)
					OP_INSERT: begin
						we = 1'b1;
					end
					OP_LOOKUP: begin
						res_frame = rd_data_q.frame;
					end
					OP_DELETE: begin
						we         = 1'b1;
						wdata      = '{st: SLOT_DELETED, key: rd_data_q.key,
							frame: rd_data_q.frame};
						count_next = count_q - CW'(1);
					end
					default: begin
						res_status = ST_NOT_FOUND;
					end
				endcase
			end else if (op_q == OP_INSERT) begin
				if (ins_ok) begin
					we         = 1'b1;
					waddr      = ins_idx;
					res_status = ST_OK;
					count_next = count_q + CW'(1);
				end else begin
					res_status = ST_FULL;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			count_q     <= '0;
			done_q      <= 1'b0;
			status_q    <= ST_NOT_FOUND;
			frame_out_q <= '0;
			op_q        <= OP_NONE;
			key_q       <= '0;
			frame_q     <= '0;
			cur_q       <= '0;
			probes_q    <= '0;
			free_have_q <= 1'b0;
			free_idx_q  <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + IDX_W'(1);
					if (clr_q == IDX_W'(ENTRIES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (!q_flags.empty) begin
						op_q        <= q_item.op;
						key_q       <= q_item.key;
						frame_q     <= q_item.frame;
						cur_q       <= q_idx;
						probes_q    <= '0;
						free_have_q <= 1'b0;
						if (q_item.op == OP_NONE) begin
							done_q      <= 1'b1;
							status_q    <= ST_NOT_FOUND;
							frame_out_q <= '0;
						end else begin
							state_q <= S_PROBE;
						end
					end
				end
				S_PROBE: begin
					if (finish) begin
						done_q      <= 1'b1;
						status_q    <= res_status;
						frame_out_q <= res_frame;
						count_q     <= count_next;
						state_q     <= S_IDLE;
					end else begin
						cur_q    <= next_idx;
						probes_q <= probes_q + IDX_W'(1);
						if (slot_free && !free_have_q) begin
							free_have_q <= 1'b1;
							free_idx_q  <= cur_q;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign frame_out   = frame_out_q;
	assign entry_count = 7'(count_q);

endmodule

@@ rtl/core/p2f_checker.sv @@
// Port-level checks for the page to frame map, bound to the top level.
module p2f_checker import p2f_pkg::*; #(
	parameter int ENTRIES = 64
) (
	input logic        clk,
	input logic        arst_n,
	input logic        busy,
	input logic        done,
	input logic [1:0]  status,
	input logic [15:0] frame_out,
	input logic [6:0]  entry_count
);

	// The memory sweep after reset must hold requests off.
	a_busy_after_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> busy)
		else $error("busy low right after reset");

	// Only a successful lookup returns a frame.
	a_frame_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> frame_out == 16'd0)
		else $error("frame_out nonzero on a failed request");

	// A full answer means every slot is in use.
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_FULL) |-> entry_count == 7'(ENTRIES))
		else $error("full reported with free slots");

	// The count never passes the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (ENTRIES > 127) || (entry_count <= 7'(ENTRIES)))
		else $error("entry_count above capacity");

endmodule

bind page_to_frame_map_top p2f_checker #(
	.ENTRIES (ENTRIES)
) u_p2f_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.busy        (busy),
	.done        (done),
	.status      (status),
	.frame_out   (frame_out),
	.entry_count (entry_count)
);

@@ tb/page_to_frame_map_top_tb.sv @@
// Self-checking testbench for the page to frame map: directed and random request beats.
`timescale 1ns / 100ps

module page_to_frame_map_top_tb import p2f_pkg::*;;

	// Table size of the block under test. The shadow map below uses the same size.
	localparam int ENTRIES = 64;
	// Size of the pool of keys that random traffic keeps reusing, so that
	// lookups, updates and deletes hit stored pairs and the table fills up.
	localparam int POOL_SIZE = 100;
	// Cycles with no accepted beat and no result before the run is given up.
	// The slowest legal request is ENTRIES probes behind a short queue, and the
	// sender's random gaps are short, so this is a generous margin.
	localparam int STALL_LIMIT = 5000;
	// Quiet cycles after the last expected result, to catch stray results.
	localparam int TAIL_CYCLES = 4 * ENTRIES;

	// One expected answer: what the block must show when done is high.
	typedef struct packed {
		status_t     status;
		logic [15:0] frame;
		logic [6:0]  count;
	} map_answer_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start = 1'b0;
	req_op_t     req_type = OP_NONE;
	logic [31:0] page_number = '0;
	logic [15:0] frame_number = '0;
	logic        busy;
	logic        done;
	logic [1:0]  status;
	logic [15:0] frame_out;
	logic [6:0]  entry_count;

	page_to_frame_map_top #(
		.ENTRIES(ENTRIES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.page_number(page_number),
		.frame_number(frame_number),
		.done(done),
		.status(status),
		.frame_out(frame_out),
		.entry_count(entry_count)
	);

	// 20 ns period: 10 ns low, 10 ns high.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Shadow copy of the map. A slot's page and frame are only read while
	// the slot is live, so they need no reset value.
	logic [31:0] held_page [ENTRIES];
	logic [15:0] held_frame [ENTRIES];
	bit          slot_live [ENTRIES];
	int          live_pairs = 0;

	// Answers owed by the block, oldest first.
	map_answer_t answers_due [$];

	logic [31:0] key_pool [POOL_SIZE];
	int          sender_idle_pct = 0;
	int          mismatch_count = 0;
	int          stalled_cycles = 0;

	// Applies one request to the shadow map and returns the answer it must give.
	// A new key goes to the first free slot; an insert of a new key into a full
	// table is dropped and answers full. The unused request code changes nothing
	// and answers not found. Only a hit lookup returns a nonzero frame.
	function automatic map_answer_t apply_request(input req_op_t op,
			input logic [31:0] page, input logic [15:0] frame);
		map_answer_t ans;
		int hit;
		int hole;
		hit = -1;
		hole = -1;
		for (int i = 0; i < ENTRIES; i++) begin
			if (slot_live[i] && held_page[i] == page && hit < 0)
				hit = i;
			if (!slot_live[i] && hole < 0)
				hole = i;
		end
		ans.status = ST_NOT_FOUND;
		ans.frame = '0;
		case (op)
			OP_INSERT: begin
				if (hit >= 0) begin
					held_frame[hit] = frame;
					ans.status = ST_OK;
				end else if (hole >= 0) begin
					held_page[hole] = page;
					held_frame[hole] = frame;
					slot_live[hole] = 1'b1;
					live_pairs++;
					ans.status = ST_OK;
				end else begin
					ans.status = ST_FULL;
				end
			end
			OP_LOOKUP: begin
				if (hit >= 0) begin
					ans.status = ST_OK;
					ans.frame = held_frame[hit];
				end
			end
			OP_DELETE: begin
				if (hit >= 0) begin
					slot_live[hit] = 1'b0;
					live_pairs--;
					ans.status = ST_OK;
				end
			end
			default: begin
			end
		endcase
		ans.count = 7'(live_pairs);
		return ans;
	endfunction

	// Returns some page that is stored in the shadow map right now.
	function automatic logic [31:0] pick_live_page();
		int first;
		int idx;
		first = $urandom_range(ENTRIES - 1);
		for (int i = 0; i < ENTRIES; i++) begin
			idx = (first + i) % ENTRIES;
			if (slot_live[idx])
				return held_page[idx];
		end
		return '0;
	endfunction

	// Key for a random request: often a stored page, so that the probe engine
	// hits, otherwise a page from the pool or, now and then, any 32-bit value.
	function automatic logic [31:0] choose_page(input req_op_t op);
		int live_share;
		live_share = (op == OP_INSERT) ? 30 : 65;
		if (live_pairs > 0 && $urandom_range(99) < live_share)
			return pick_live_page();
		if ($urandom_range(99) < 85)
			return key_pool[$urandom_range(POOL_SIZE - 1)];
		return $urandom;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatch_count++;
		$display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h",
			$realtime, what, got, want);
	endtask

	// Sends one request beat. Start is left high after the beat is taken, so a
	// following beat without a gap goes out on the very next edge; start only
	// drops when a gap is drawn or when the stimulus stops. The expected answer
	// is worked out at the edge that takes the beat.
	task automatic send_request(input req_op_t op, input logic [31:0] page,
			input logic [15:0] frame);
		if ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < sender_idle_pct);
		end
		start <= 1'b1;
		req_type <= op;
		page_number <= page;
		frame_number <= frame;
		do
			@(posedge clk);
		while (busy);
		answers_due.push_back(apply_request(op, page, frame));
	endtask

	// Results are sampled at the falling edge, half a cycle away from every
	// change on either side, so the order of events at the rising edge cannot
	// matter. The watchdog runs here too: an accepted beat shows as start high
	// and busy low in the middle of the cycle whose end takes it.
	always @(negedge clk) begin : watch_results
		map_answer_t want;
		if (arst_n && done) begin
			if (answers_due.size() == 0) begin
				report_mismatch("unexpected result status", 32'(status), 32'(ST_OK));
			end else begin
				want = answers_due.pop_front();
				if (status !== want.status)
					report_mismatch("status", 32'(status), 32'(want.status));
				if (frame_out !== want.frame)
					report_mismatch("frame_out", 32'(frame_out), 32'(want.frame));
				if (entry_count !== want.count)
					report_mismatch("entry_count", 32'(entry_count), 32'(want.count));
			end
		end
		if (!arst_n || done || (start && !busy))
			stalled_cycles = 0;
		else
			stalled_cycles++;
		if (stalled_cycles >= STALL_LIMIT) begin
			$display("FAIL page_to_frame_map_top");
			$finish;
		end
	end

	// Requests against an empty map: a lookup and a delete miss, the unused code too.
	task automatic test_empty_map();
		send_request(OP_LOOKUP, 32'h0000_0000, 16'hFFFF);
		send_request(OP_DELETE, 32'hFFFF_FFFF, 16'h0000);
		send_request(OP_NONE, 32'h0000_0000, 16'hFFFF);
	endtask

	// Extreme keys and frames: insert, update in place, lookup, delete, and
	// a repeated delete and lookup of a page that is gone.
	task automatic test_extreme_pairs();
		send_request(OP_INSERT, 32'h0000_0000, 16'h0000);
		send_request(OP_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
		send_request(OP_LOOKUP, 32'h0000_0000, 16'h1234);
		send_request(OP_LOOKUP, 32'hFFFF_FFFF, 16'h0000);
		send_request(OP_INSERT, 32'h0000_0000, 16'hFFFF);
		send_request(OP_LOOKUP, 32'h0000_0000, 16'h0000);
		send_request(OP_INSERT, 32'hFFFF_FFFF, 16'h0000);
		send_request(OP_LOOKUP, 32'hFFFF_FFFF, 16'hFFFF);
		send_request(OP_LOOKUP, 32'h0000_0001, 16'h0000);
		send_request(OP_DELETE, 32'hFFFF_FFFF, 16'hFFFF);
		send_request(OP_LOOKUP, 32'hFFFF_FFFF, 16'h0000);
		send_request(OP_DELETE, 32'hFFFF_FFFF, 16'h0000);
		send_request(OP_NONE, 32'hFFFF_FFFF, 16'hFFFF);
		send_request(OP_DELETE, 32'h0000_0000, 16'h0000);
		send_request(OP_LOOKUP, 32'h0000_0000, 16'h0000);
	endtask

	// Fills every slot, then checks that a new key is refused while an update
	// of a stored key still succeeds, and that a delete makes room again.
	task automatic test_full_table();
		int n;
		n = 0;
		while (live_pairs < ENTRIES) begin
			send_request(OP_INSERT, 32'hA5A5_0000 + 32'(n), 16'(n * 977));
			n++;
		end
		send_request(OP_INSERT, 32'h5A5A_FFFF, 16'hBEEF);
		send_request(OP_INSERT, 32'hA5A5_0003, 16'hFFFF);
		send_request(OP_LOOKUP, 32'hA5A5_0003, 16'h0000);
		send_request(OP_NONE, 32'h5A5A_FFFF, 16'h0000);
		send_request(OP_DELETE, 32'hA5A5_0007, 16'h0000);
		send_request(OP_INSERT, 32'h5A5A_FFFF, 16'hBEEF);
		send_request(OP_INSERT, 32'h5A5A_FFFE, 16'hCAFE);
		send_request(OP_LOOKUP, 32'h5A5A_FFFF, 16'h0000);
		send_request(OP_LOOKUP, 32'hA5A5_0007, 16'h0000);
	endtask

	// Random traffic with a given share of inserts and deletes; the rest are
	// lookups, with a few beats of the unused request code mixed in.
	task automatic test_random_traffic(input int beats, input int insert_pct,
			input int delete_pct);
		req_op_t op;
		int roll;
		repeat (beats) begin
			roll = $urandom_range(99);
			if (roll < insert_pct)
				op = OP_INSERT;
			else if (roll < insert_pct + delete_pct)
				op = OP_DELETE;
			else if (roll < 97)
				op = OP_LOOKUP;
			else
				op = OP_NONE;
			send_request(op, choose_page(op), 16'($urandom));
		end
	endtask

	// Stops the stimulus, waits for every owed answer and then for a quiet
	// tail in which any extra result would be flagged as unexpected.
	task automatic drain_results();
		start <= 1'b0;
		while (answers_due.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES)
			@(posedge clk);
	endtask

	initial begin
		// Reset goes low once every process waits on its events, so the
		// asynchronous reset of the block sees a falling edge.
		arst_n <= 1'b0;
		key_pool[0] = 32'h0000_0000;
		key_pool[1] = 32'hFFFF_FFFF;
		for (int i = 2; i < POOL_SIZE; i++)
			key_pool[i] = $urandom;

		// Reset is held low and then released on a rising edge. The block then sweeps
		// its slot memory with busy high; the first beat simply waits for it.
		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;

		// Sender idles often in the first phase, very often in the second,
		// and never in the last. The result side cannot be held off.
		sender_idle_pct = 35;
		test_empty_map();
		test_extreme_pairs();
		test_full_table();
		// Insert heavy: the table stays near full and refuses new keys.
		test_random_traffic(290, 55, 15);
		sender_idle_pct = 74;
		// Delete heavy: the table empties and lookups and deletes miss.
		test_random_traffic(280, 25, 45);
		sender_idle_pct = 0;
		// Balanced, back to back.
		test_random_traffic(290, 40, 30);

		drain_results();
		if (mismatch_count == 0 && answers_due.size() == 0)
			$display("PASS page_to_frame_map_top");
		else
			$display("FAIL page_to_frame_map_top");
		$finish;
	end

endmodule

@@ page_to_frame_map_top.f @@
rtl/core/p2f_pkg.sv
rtl/core/p2f_front.sv
rtl/core/p2f_queue.sv
rtl/core/p2f_back.sv
rtl/core/page_to_frame_map_top.sv
rtl/core/p2f_checker.sv
tb/page_to_frame_map_top_tb.sv
